// ----- hw/rtl/lssc_pkg.sv -----
package lssc_pkg;

    localparam int SENSOR_COUNT = 12;
    localparam int SAMPLE_BITS  = 12;

    localparam int IDX_W      = 4;
    localparam int SUM_W      = 15;
    localparam int DIFF_W     = 16;
    localparam int DD_W       = 17;
    localparam int GAIN_W     = 24;
    localparam int THR_W      = 15;
    localparam int LIM_W      = 12;
    localparam int CNT_W      = 16;
    localparam int STEER_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CMUL_W     = 17;

    localparam logic [CMUL_W-1:0] CURVE_MUL = CMUL_W'(85197);

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;
    localparam logic [1:0] ACT_RESET  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_AVG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_FRAMES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FRAMES = 3'd6;

    localparam logic [GAIN_W-1:0] RST_PROP_GAIN   = GAIN_W'(16777);
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN  = GAIN_W'(6711);
    localparam logic [THR_W-1:0]  RST_CURVE_THR   = THR_W'(500);
    localparam logic [LIM_W-1:0]  RST_DARK_AVG    = LIM_W'(920);
    localparam logic [LIM_W-1:0]  RST_SENSOR_HIGH = LIM_W'(500);
    localparam logic [CNT_W-1:0]  RST_DARK_FRAMES = CNT_W'(80);
    localparam logic [CNT_W-1:0]  RST_HIGH_FRAMES = CNT_W'(70);

    typedef struct packed {
        logic [1:0]             action;
        logic [IDX_W-1:0]       sensor_index;
        logic [SAMPLE_BITS-1:0] sensor_value;
    } lssc_req_t;

    typedef struct packed {
        logic signed [STEER_W-1:0] steer_term;
        logic                      on_curve;
        logic                      course_out;
        logic                      course_out_cause;
        logic                      tracking_active;
    } lssc_res_t;

    typedef struct packed {
        logic take;
        logic eval;
        logic mul;
        logic add;
        logic cmul;
        logic merge;
        logic load;
    } lssc_cmd_t;

    typedef struct packed {
        logic close_active;
    } lssc_status_t;

endpackage

// ----- hw/rtl/lssc_ctrl.sv -----
module lssc_ctrl
    import lssc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  lssc_status_t status,
    output lssc_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FRAME = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_CMUL  = 3'd4;
    localparam logic [2:0] ST_MERGE = 3'd5;
    localparam logic [2:0] ST_ROUND = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd       = '0;
        cmd.take  = s_valid && s_ready;
        cmd.eval  = (state_reg == ST_FRAME);
        cmd.mul   = (state_reg == ST_MUL);
        cmd.add   = (state_reg == ST_ADD);
        cmd.cmul  = (state_reg == ST_CMUL);
        cmd.merge = (state_reg == ST_MERGE);
        cmd.load  = (state_reg == ST_ROUND) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.take && status.close_active) begin
                    state_next = ST_FRAME;
                end
            end
            ST_FRAME: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_CMUL;
            ST_CMUL:  state_next = ST_MERGE;
            ST_MERGE: state_next = ST_ROUND;
            ST_ROUND: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_frame_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take && status.close_active) |-> ##6 (state_reg == ST_ROUND))
        else $error("frame did not reach rounding stage on time");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("pending result dropped");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request taken while frame in flight");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_ROUND))
        else $error("result raised outside rounding stage");

endmodule

// ----- hw/rtl/lssc_dp.sv -----
module lssc_dp
    import lssc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lssc_cmd_t             cmd,
    output lssc_status_t          status,
    input  lssc_req_t             s_data,
    output lssc_res_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int P1_W    = GAIN_W + 1 + DIFF_W;
    localparam int P2_W    = GAIN_W + 1 + DD_W;
    localparam int S_W     = P2_W + 1;
    localparam int LO_W    = 22;
    localparam int HI_W    = S_W - LO_W;
    localparam int MLO_W   = LO_W + CMUL_W;
    localparam int MHI_W   = HI_W + CMUL_W + 1;
    localparam int PROD_W  = S_W + CMUL_W;
    localparam int BOUND_W = LIM_W + 6;

    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] deriv_gain_reg;
    logic [THR_W-1:0]  curve_thr_reg;
    logic [LIM_W-1:0]  dark_avg_reg;
    logic [LIM_W-1:0]  sensor_high_reg;
    logic [CNT_W-1:0]  dark_frames_reg;
    logic [CNT_W-1:0]  high_frames_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= RST_PROP_GAIN;
            deriv_gain_reg  <= RST_DERIV_GAIN;
            curve_thr_reg   <= RST_CURVE_THR;
            dark_avg_reg    <= RST_DARK_AVG;
            sensor_high_reg <= RST_SENSOR_HIGH;
            dark_frames_reg <= RST_DARK_FRAMES;
            high_frames_reg <= RST_HIGH_FRAMES;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_CURVE_THR:   curve_thr_reg   <= cfg_data[THR_W-1:0];
                REG_DARK_AVG:    dark_avg_reg    <= cfg_data[LIM_W-1:0];
                REG_SENSOR_HIGH: sensor_high_reg <= cfg_data[LIM_W-1:0];
                REG_DARK_FRAMES: dark_frames_reg <= cfg_data[CNT_W-1:0];
                REG_HIGH_FRAMES: high_frames_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SUM_W-1:0]         left_reg, left_next;
    logic [SUM_W-1:0]         right_reg, right_next;
    logic                     all_high_reg, all_high_next;
    logic signed [DIFF_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0]         dark_cnt_reg, dark_cnt_next;
    logic [CNT_W-1:0]         high_cnt_reg, high_cnt_next;
    logic                     active_reg, active_next;

    logic             in_range, is_left, is_close, is_high;
    logic [SUM_W-1:0] left_add, right_add;

    assign in_range  = s_data.sensor_index < IDX_W'(SENSOR_COUNT);
    assign is_left   = s_data.sensor_index < IDX_W'(SENSOR_COUNT / 2);
    assign is_close  = s_data.sensor_index == IDX_W'(SENSOR_COUNT - 1);
    assign is_high   = s_data.sensor_value > sensor_high_reg;
    assign left_add  = left_reg + SUM_W'(s_data.sensor_value);
    assign right_add = right_reg + SUM_W'(s_data.sensor_value);

    assign status.close_active = (s_data.action == ACT_SAMPLE) && is_close && active_reg;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] mag;
    logic signed [DD_W-1:0]   dd;
    logic                     curve;
    logic [DIFF_W-1:0]        total;
    logic [BOUND_W-1:0]       dark_bound;
    logic                     is_dark;
    logic [CNT_W-1:0]         dark_cnt_new, high_cnt_new;
    logic                     dark_hit, high_hit, out_now;

    assign diff  = $signed({1'b0, left_reg}) - $signed({1'b0, right_reg});
    assign mag   = diff[DIFF_W-1] ? -diff : diff;
    assign curve = mag >= $signed({1'b0, curve_thr_reg});
    assign dd    = {diff[DIFF_W-1], diff} - {prev_reg[DIFF_W-1], prev_reg};
    assign total = {1'b0, left_reg} + {1'b0, right_reg};

    assign dark_bound   = BOUND_W'(dark_avg_reg) * BOUND_W'(SENSOR_COUNT)
                        + BOUND_W'(SENSOR_COUNT - 1);
    assign is_dark      = BOUND_W'(total) > dark_bound;
    assign dark_cnt_new = is_dark ? dark_cnt_reg + CNT_W'(1) : '0;
    assign high_cnt_new = all_high_reg ? high_cnt_reg + CNT_W'(1) : '0;
    assign dark_hit     = dark_cnt_new >= dark_frames_reg;
    assign high_hit     = high_cnt_new >= high_frames_reg;
    assign out_now      = dark_hit || high_hit;

    always_comb begin
        left_next     = left_reg;
        right_next    = right_reg;
        all_high_next = all_high_reg;
        prev_next     = prev_reg;
        dark_cnt_next = dark_cnt_reg;
        high_cnt_next = high_cnt_reg;
        active_next   = active_reg;
        if (cmd.take) begin
            case (s_data.action)
                ACT_SAMPLE: begin
                    if (in_range) begin
                        if (is_close && !active_reg) begin
                            left_next     = '0;
                            right_next    = '0;
                            all_high_next = 1'b1;
                        end else begin
                            if (is_left) begin
                                left_next = left_add;
                            end else begin
                                right_next = right_add;
                            end
                            if (!is_high) begin
                                all_high_next = 1'b0;
                            end
                        end
                    end
                end
                ACT_START: active_next = 1'b1;
                ACT_STOP:  active_next = 1'b0;
                ACT_RESET: begin
                    prev_next   = '0;
                    active_next = 1'b0;
                end
                default: ;
            endcase
        end
        if (cmd.eval) begin
            left_next     = '0;
            right_next    = '0;
            all_high_next = 1'b1;
            prev_next     = diff;
            dark_cnt_next = dark_cnt_new;
            high_cnt_next = high_cnt_new;
            active_next   = !out_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= '0;
            right_reg    <= '0;
            all_high_reg <= 1'b1;
            prev_reg     <= '0;
            dark_cnt_reg <= '0;
            high_cnt_reg <= '0;
            active_reg   <= 1'b0;
        end else begin
            left_reg     <= left_next;
            right_reg    <= right_next;
            all_high_reg <= all_high_next;
            prev_reg     <= prev_next;
            dark_cnt_reg <= dark_cnt_next;
            high_cnt_reg <= high_cnt_next;
            active_reg   <= active_next;
        end
    end

    logic signed [DIFF_W-1:0] d_reg;
    logic signed [DD_W-1:0]   dd_reg;
    logic                     curve_reg;
    logic                     co_reg;
    logic                     cause_reg;
    logic signed [P1_W-1:0]   p1_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic signed [S_W-1:0]    s_reg;
    logic [MLO_W-1:0]         mlo_reg;
    logic signed [MHI_W-1:0]  mhi_reg;
    logic signed [PROD_W-1:0] prod_reg;
    lssc_res_t                res_reg;

    logic [LO_W-1:0]          s_lo;
    logic signed [HI_W-1:0]   s_hi;
    logic signed [PROD_W-1:0] mhi_ext, mlo_ext, s_ext, prod_next;
    logic signed [PROD_W-1:0] rnd_y, rnd_r;
    logic                     pos_ovf, neg_ovf;
    logic signed [STEER_W-1:0] steer;

    assign s_lo    = s_reg[LO_W-1:0];
    assign s_hi    = s_reg[S_W-1:LO_W];
    assign mhi_ext = {{(PROD_W - MHI_W){mhi_reg[MHI_W-1]}}, mhi_reg};
    assign mlo_ext = {{(PROD_W - MLO_W){1'b0}}, mlo_reg};
    assign s_ext   = {{(PROD_W - S_W){s_reg[S_W-1]}}, s_reg};

    always_comb begin
        if (curve_reg) begin
            prod_next = (mhi_ext <<< LO_W) + mlo_ext;
        end else begin
            prod_next = s_ext;
        end
    end

    always_comb begin
        if (curve_reg) begin
            rnd_y = prod_reg + (PROD_W'(1) <<< 23);
            rnd_r = rnd_y >>> 24;
        end else begin
            rnd_y = prod_reg + (PROD_W'(1) <<< 7);
            rnd_r = rnd_y >>> 8;
        end
    end

    assign pos_ovf = !rnd_r[PROD_W-1] && (|rnd_r[PROD_W-2:STEER_W-1]);
    assign neg_ovf = rnd_r[PROD_W-1] && !(&rnd_r[PROD_W-2:STEER_W-1]);

    always_comb begin
        if (pos_ovf) begin
            steer = {1'b0, {(STEER_W - 1){1'b1}}};
        end else if (neg_ovf) begin
            steer = {1'b1, {(STEER_W - 1){1'b0}}};
        end else begin
            steer = rnd_r[STEER_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            d_reg     <= diff;
            dd_reg    <= dd;
            curve_reg <= curve;
            co_reg    <= out_now;
            cause_reg <= out_now && dark_hit;
        end
        if (cmd.mul) begin
            p1_reg <= P1_W'($signed({1'b0, prop_gain_reg})) * P1_W'(d_reg);
            p2_reg <= P2_W'($signed({1'b0, deriv_gain_reg})) * P2_W'(dd_reg);
        end
        if (cmd.add) begin
            s_reg <= {{(S_W - P1_W){p1_reg[P1_W-1]}}, p1_reg}
                   + {{(S_W - P2_W){p2_reg[P2_W-1]}}, p2_reg};
        end
        if (cmd.cmul) begin
            mlo_reg <= MLO_W'(s_lo) * MLO_W'(CURVE_MUL);
            mhi_reg <= MHI_W'(s_hi) * MHI_W'($signed({1'b0, CURVE_MUL}));
        end
        if (cmd.merge) begin
            prod_reg <= prod_next;
        end
        if (cmd.load) begin
            res_reg.steer_term       <= steer;
            res_reg.on_curve         <= curve_reg;
            res_reg.course_out       <= co_reg;
            res_reg.course_out_cause <= cause_reg;
            res_reg.tracking_active  <= active_reg;
        end
    end

    assign m_data = res_reg;

endmodule

// ----- hw/rtl/line_sensor_steering_and_course_out.sv -----
// Channel   Direction  Ports                             Carries
// request   in         s_valid s_ready s_data            action, sensor index, sample
// result    out        m_valid m_ready m_data            steer term, curve, course-out, tracking
// config    in         cfg_we cfg_index cfg_data         register writes, no read-back
//
// A request that does not close a tracked frame leaves the controller idle.
// A closing sample while tracking passes these steps to the result register: frame
// evaluation, two gain multipliers, sum, split curve multiply, merge, round and clamp.
// No request is taken while a frame is in flight; a waiting result stalls only the
// rounding stage. Reset is synchronous on aresetn low.
module line_sensor_steering_and_course_out
    import lssc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lssc_req_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lssc_res_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lssc_cmd_t    cmd;
    lssc_status_t status;

    lssc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lssc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- tb/line_sensor_steering_and_course_out_tb.sv -----
module line_sensor_steering_and_course_out_tb;
    import lssc_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 12;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    lssc_req_t             s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    lssc_res_t             m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    line_sensor_steering_and_course_out DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // steering model: configuration
    logic [GAIN_W-1:0] k_prop = RST_PROP_GAIN;
    logic [GAIN_W-1:0] k_deriv = RST_DERIV_GAIN;
    logic [THR_W-1:0]  thr_curve = RST_CURVE_THR;
    logic [LIM_W-1:0]  lim_dark_avg = RST_DARK_AVG;
    logic [LIM_W-1:0]  lim_sensor_high = RST_SENSOR_HIGH;
    logic [CNT_W-1:0]  lim_dark_frames = RST_DARK_FRAMES;
    logic [CNT_W-1:0]  lim_high_frames = RST_HIGH_FRAMES;

    // steering model: state
    logic [SUM_W-1:0]          acc_left = '0;
    logic [SUM_W-1:0]          acc_right = '0;
    logic                      frame_all_high = 1'b1;
    int                        last_diff = 0;
    logic signed [STEER_W-1:0] steer_hold = '0;
    logic                      curve_seen = 1'b0;
    logic [CNT_W-1:0]          dark_run = '0;
    logic [CNT_W-1:0]          high_run = '0;
    logic                      tracking = 1'b0;

    lssc_req_t sample_pend_q[$];
    lssc_res_t steer_expect_q[$];

    int  err_count = 0;
    int  req_count = 0;
    int  res_count = 0;
    int  course_out_count = 0;
    int  settings_count = 0;
    int  phase_items = 0;
    logic no_idle = 1'b0;
    logic hold_armed = 1'b0;

    task automatic predict_frame_step(input lssc_req_t rq);
        int        d;
        int        mag;
        int        avg;
        longint    s;
        longint    r;
        logic      curve;
        logic      dark_hit;
        logic      high_hit;
        logic      out_now;
        lssc_res_t res;
        case (rq.action)
            ACT_START: begin
                tracking = 1'b1;
            end
            ACT_STOP: begin
                tracking = 1'b0;
                steer_hold = '0;
            end
            ACT_RESET: begin
                last_diff = 0;
                steer_hold = '0;
                curve_seen = 1'b0;
                tracking = 1'b0;
            end
            default: begin
                if (rq.sensor_index < SENSOR_COUNT) begin
                    if (rq.sensor_index < SENSOR_COUNT / 2)
                        acc_left = acc_left + rq.sensor_value;
                    else
                        acc_right = acc_right + rq.sensor_value;
                    if (rq.sensor_value <= lim_sensor_high)
                        frame_all_high = 1'b0;
                    if (rq.sensor_index == SENSOR_COUNT - 1) begin
                        if (tracking) begin
                            d = int'(acc_left) - int'(acc_right);
                            mag = (d < 0) ? -d : d;
                            curve = mag >= int'(thr_curve);
                            s = longint'(k_prop) * longint'(d)
                                + longint'(k_deriv) * longint'(d - last_diff);
                            if (curve)
                                r = (s * longint'(CURVE_MUL) + (longint'(1) << 23)) >>> 24;
                            else
                                r = (s + (longint'(1) << 7)) >>> 8;
                            if (r > (longint'(1) << (STEER_W - 1)) - 1)
                                r = (longint'(1) << (STEER_W - 1)) - 1;
                            if (r < -(longint'(1) << (STEER_W - 1)))
                                r = -(longint'(1) << (STEER_W - 1));
                            steer_hold = r[STEER_W-1:0];
                            curve_seen = curve;
                            last_diff = d;
                            avg = (int'(acc_left) + int'(acc_right)) / SENSOR_COUNT;
                            if (avg > int'(lim_dark_avg))
                                dark_run = dark_run + 1'b1;
                            else
                                dark_run = '0;
                            if (frame_all_high)
                                high_run = high_run + 1'b1;
                            else
                                high_run = '0;
                            dark_hit = dark_run >= lim_dark_frames;
                            high_hit = high_run >= lim_high_frames;
                            out_now = dark_hit || high_hit;
                            if (out_now)
                                tracking = 1'b0;
                            res.steer_term = steer_hold;
                            res.on_curve = curve_seen;
                            res.course_out = out_now;
                            res.course_out_cause = out_now && dark_hit;
                            res.tracking_active = tracking;
                            steer_expect_q.push_back(res);
                        end
                        acc_left = '0;
                        acc_right = '0;
                        frame_all_high = 1'b1;
                    end
                end
            end
        endcase
    endtask

    // request driver
    always @(posedge aclk) begin : req_drive
        int s_gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_frame_step(s_data);
                req_count++;
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (sample_pend_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 11) == 0) begin
                    s_gap = $urandom_range(1, 17) - 1;
                    s_valid <= 1'b0;
                end else begin
                    s_data <= sample_pend_q.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : res_check
        lssc_res_t want;
        int r_gap;
        int hold_cnt;
        if (!aresetn) begin
            m_ready <= 1'b0;
            r_gap = 0;
            hold_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (steer_expect_q.size() == 0) begin
                    $error("unexpected result: steer_term %0d", m_data.steer_term);
                    err_count++;
                end else begin
                    want = steer_expect_q.pop_front();
                    res_count++;
                    if (m_data.course_out)
                        course_out_count++;
                    if (m_data.steer_term !== want.steer_term) begin
                        $error("steer_term: expected %0d, actual %0d",
                               want.steer_term, m_data.steer_term);
                        err_count++;
                    end
                    if (m_data.on_curve !== want.on_curve) begin
                        $error("on_curve: expected %0d, actual %0d",
                               want.on_curve, m_data.on_curve);
                        err_count++;
                    end
                    if (m_data.course_out !== want.course_out) begin
                        $error("course_out: expected %0d, actual %0d",
                               want.course_out, m_data.course_out);
                        err_count++;
                    end
                    if (m_data.course_out_cause !== want.course_out_cause) begin
                        $error("course_out_cause: expected %0d, actual %0d",
                               want.course_out_cause, m_data.course_out_cause);
                        err_count++;
                    end
                    if (m_data.tracking_active !== want.tracking_active) begin
                        $error("tracking_active: expected %0d, actual %0d",
                               want.tracking_active, m_data.tracking_active);
                        err_count++;
                    end
                end
            end
            if (hold_armed && hold_cnt < HOLD_CYCLES) begin
                hold_cnt++;
                m_ready <= 1'b0;
            end else if (r_gap > 0) begin
                r_gap--;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                r_gap = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin : stall_watch
        int stall_cnt;
        if (!aresetn) begin
            stall_cnt = 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("line_sensor_steering_and_course_out test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_PROP_GAIN:   k_prop = val[GAIN_W-1:0];
            REG_DERIV_GAIN:  k_deriv = val[GAIN_W-1:0];
            REG_CURVE_THR:   thr_curve = val[THR_W-1:0];
            REG_DARK_AVG:    lim_dark_avg = val[LIM_W-1:0];
            REG_SENSOR_HIGH: lim_sensor_high = val[LIM_W-1:0];
            REG_DARK_FRAMES: lim_dark_frames = val[CNT_W-1:0];
            REG_HIGH_FRAMES: lim_high_frames = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input int pg, input int dg, input int thr, input int davg,
                                 input int shigh, input int dlim, input int hlim);
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(pg));
        write_reg(REG_DERIV_GAIN, CFG_DATA_W'(dg));
        write_reg(REG_CURVE_THR, CFG_DATA_W'(thr));
        write_reg(REG_DARK_AVG, CFG_DATA_W'(davg));
        write_reg(REG_SENSOR_HIGH, CFG_DATA_W'(shigh));
        write_reg(REG_DARK_FRAMES, CFG_DATA_W'(dlim));
        write_reg(REG_HIGH_FRAMES, CFG_DATA_W'(hlim));
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic queue_req(input logic [1:0] act, input int idx, input int val);
        lssc_req_t rq;
        rq.action = act;
        rq.sensor_index = idx[IDX_W-1:0];
        rq.sensor_value = val[SAMPLE_BITS-1:0];
        sample_pend_q.push_back(rq);
        if (!(act == ACT_SAMPLE && idx >= SENSOR_COUNT))
            phase_items++;
    endtask

    function automatic int pick_sample(input int mode, input int idx);
        case (mode)
            0: return $urandom_range(0, 4095);
            1: return (idx < SENSOR_COUNT / 2) ? $urandom_range(2500, 4095)
                                               : $urandom_range(0, 800);
            2: return (idx < SENSOR_COUNT / 2) ? $urandom_range(0, 800)
                                               : $urandom_range(2500, 4095);
            3: return $urandom_range(3000, 4095);
            4: return $urandom_range(0, 300);
            default: return $urandom_range(0, 1) ? 4095 : 0;
        endcase
    endfunction

    task automatic queue_frame();
        int mode;
        int n;
        int act_pick;
        mode = $urandom_range(0, 6);
        if ($urandom_range(0, 24) == 0)
            queue_req(ACT_RESET, $urandom_range(0, 15), $urandom_range(0, 4095));
        if ($urandom_range(0, 19) == 0)
            queue_req(ACT_STOP, $urandom_range(0, 15), $urandom_range(0, 4095));
        if ($urandom_range(0, 2) != 0)
            queue_req(ACT_START, $urandom_range(0, 15), $urandom_range(0, 4095));
        if (mode == 6) begin
            // broken frame: stray indices, repeats, mixed actions
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                act_pick = $urandom_range(0, 9);
                if (act_pick == 0)
                    queue_req(ACT_START, $urandom_range(0, 15), $urandom_range(0, 4095));
                else if (act_pick == 1)
                    queue_req(ACT_STOP, $urandom_range(0, 15), $urandom_range(0, 4095));
                else
                    queue_req(ACT_SAMPLE, $urandom_range(0, 15),
                              pick_sample($urandom_range(0, 5), $urandom_range(0, 11)));
            end
            if ($urandom_range(0, 1))
                queue_req(ACT_SAMPLE, SENSOR_COUNT - 1, $urandom_range(0, 4095));
        end else begin
            for (int i = 0; i < SENSOR_COUNT; i++)
                queue_req(ACT_SAMPLE, i, pick_sample(mode, i));
        end
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (sample_pend_q.size() != 0 || s_valid || steer_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(input int count);
        phase_items = 0;
        while (phase_items < count)
            queue_frame();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        load_settings(RST_PROP_GAIN, RST_DERIV_GAIN, RST_CURVE_THR, RST_DARK_AVG,
                      RST_SENSOR_HIGH, RST_DARK_FRAMES, RST_HIGH_FRAMES);
        queue_req(ACT_START, 0, 0);
        for (int i = 0; i < SENSOR_COUNT; i++)
            queue_req(ACT_SAMPLE, i, (i < SENSOR_COUNT / 2) ? 4095 : 0);
        for (int i = 0; i < 3; i++)
            queue_req(ACT_SAMPLE, SENSOR_COUNT / 2, 4095);
        queue_req(ACT_SAMPLE, SENSOR_COUNT - 1, 0);
        queue_req(ACT_STOP, 15, 4095);
        queue_req(ACT_SAMPLE, SENSOR_COUNT - 1, 4095);
        queue_req(ACT_RESET, 0, 0);
        queue_req(ACT_SAMPLE, SENSOR_COUNT, 4095);
        queue_req(ACT_SAMPLE, 15, 0);
        queue_random(110);
        wait_idle();

        load_settings(24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 1, 1);
        queue_random(120);
        wait_idle();

        load_settings(0, 0, 15'h7FFF, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
        queue_random(120);
        wait_idle();

        load_settings($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 24570), $urandom_range(1500, 3500),
                      $urandom_range(2000, 3500), $urandom_range(1, 4), $urandom_range(1, 4));
        queue_random(120);
        wait_idle();

        load_settings(RST_PROP_GAIN, RST_DERIV_GAIN, RST_CURVE_THR, RST_DARK_AVG,
                      RST_SENSOR_HIGH, 0, 0);
        queue_random(120);
        wait_idle();

        // hold results back while requests keep coming
        load_settings($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                      500, 2000, 3000, 3, 3);
        hold_armed <= 1'b1;
        queue_random(120);
        wait_idle();

        load_settings($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 15'h7FFF), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(1, 8), $urandom_range(1, 8));
        no_idle <= 1'b1;
        queue_random(120);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (steer_expect_q.size() != 0) begin
            $error("%0d expected results never arrived", steer_expect_q.size());
            err_count++;
        end
        $display("Run covered %0d requests and %0d checked frame results over %0d settings,",
                 req_count, res_count, settings_count);
        $display("including %0d course-out frames and a long result stall.", course_out_count);
        if (err_count == 0) begin
            $display("line_sensor_steering_and_course_out test passed");
        end else begin
            $display("line_sensor_steering_and_course_out test failed");
        end
        $finish;
    end

endmodule
